### rtl/core/hid_pointer_report_converter_unit_defines.svh
// assertion macros for the pointer report converter
`ifndef HID_POINTER_REPORT_CONVERTER_UNIT_DEFINES_SVH
`define HID_POINTER_REPORT_CONVERTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define HPRC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPRC_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HPRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define HPRC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/core/hprc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hprc_pkg;
	localparam int unsigned HDR_DEPTH = 7;
	localparam int unsigned CNT_W = 5;
	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;
	localparam logic [CNT_W-1:0] BASIC_MIN_LEN = 5'd4;
	localparam logic [CNT_W-1:0] WIDE_LEN = 5'd7;
	localparam logic [CNT_W-1:0] PAD_LEN = 5'd19;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [6:0] CONTACT_NONE = 7'd0;
	localparam logic [6:0] CONTACT_ONE = 7'd1;
	localparam logic [6:0] CONTACT_TWO = 7'd2;
	localparam logic [4:0] SENS_RESET = 5'd1;
	localparam logic [10:0] JUMP_RESET = 11'd150;
	localparam int unsigned DIV_STEPS = 12;

	typedef enum logic [1:0] {
		KIND_BASIC = 2'd0,
		KIND_WIDE = 2'd1,
		KIND_PAD = 2'd2
	} kind_t;

	typedef enum logic {
		REG_SENS = 1'b0,
		REG_JUMP = 1'b1
	} reg_idx_t;

	typedef struct packed {
		kind_t kind;
		logic [HDR_DEPTH-1:0][7:0] hdr;
		logic [7:0] tail_byte;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic [4:0] buttons;
		logic [11:0] move_x;
		logic [11:0] move_y;
		logic [7:0] scroll_vertical;
		logic [7:0] scroll_horizontal;
		logic last_of_run;
	} result_t;
endpackage
`default_nettype wire

### rtl/core/hprc_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module hprc_divider
	import hprc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [11:0] dividend,
	input wire logic [4:0] divisor,
	output logic busy,
	output logic [11:0] quotient
);
	logic busy_q;
	logic [3:0] step_q;
	logic [11:0] quo_q;
	logic [4:0] rem_q;
	logic [4:0] div_q;
	logic [5:0] trial;
	logic ge;
	logic [5:0] diff;

	assign trial = {rem_q, quo_q[11]};
	assign ge = trial >= {1'b0, div_q};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 4'd1;
			if (step_q == 4'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= (divisor == 5'd0) ? 5'd1 : divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[10:0], ge};
			rem_q <= ge ? diff[4:0] : trial[4:0];
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

### rtl/core/hprc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hprc_front
	import hprc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic s_axis_tlast,
	input wire q_status_t q_status,
	output logic push,
	output cmd_t push_cmd
);
	logic [CNT_W-1:0] byte_count_q;
	logic [HDR_DEPTH-1:0][7:0] header_q;
	logic accept;
	logic [CNT_W-1:0] len;
	logic known;

	assign s_axis_tready = !q_status.full;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign len = (byte_count_q == CNT_MAX) ? CNT_MAX : byte_count_q + 5'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				byte_count_q <= '0;
			end else if (byte_count_q != CNT_MAX) begin
				byte_count_q <= byte_count_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && byte_count_q < 5'(HDR_DEPTH)) begin
			header_q[byte_count_q[2:0]] <= s_axis_tdata;
		end
	end

	// current byte joins the stored header
	always_comb begin
		push_cmd.hdr = header_q;
		if (byte_count_q < 5'(HDR_DEPTH)) begin
			push_cmd.hdr[byte_count_q[2:0]] = s_axis_tdata;
		end
		push_cmd.tail_byte = s_axis_tdata;
		push_cmd.kind = KIND_BASIC;
		known = 1'b0;
		if (len == WIDE_LEN) begin
			push_cmd.kind = KIND_WIDE;
			known = 1'b1;
		end else if (len == PAD_LEN) begin
			push_cmd.kind = KIND_PAD;
			known = 1'b1;
		end else if (len >= BASIC_MIN_LEN && len < WIDE_LEN) begin
			known = 1'b1;
		end
	end

	assign push = accept && s_axis_tlast && known;
endmodule
`default_nettype wire

### rtl/core/hprc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hid_pointer_report_converter_unit_defines.svh"
module hprc_queue
	import hprc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cmd_t push_cmd,
	input wire logic pop,
	output cmd_t head_cmd,
	output q_status_t status
);
	cmd_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head_cmd = mem_q[rd_ptr_q];
	assign status.full = count_q == QCNT_W'(QUEUE_DEPTH);
	assign status.empty = count_q == '0;

	`HPRC_NEVER(a_no_overflow, clk, arst_n, push && status.full, "push into full queue")
	`HPRC_NEVER(a_no_underflow, clk, arst_n, pop && status.empty, "pop from empty queue")
	`HPRC_ASSERT(a_count_range, clk, arst_n, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
endmodule
`default_nettype wire

### rtl/core/hprc_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "hid_pointer_report_converter_unit_defines.svh"
module hprc_back
	import hprc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t head_cmd,
	input wire q_status_t q_status,
	output logic pop,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [10:0] cfg_data,
	output logic m_valid,
	input wire logic m_ready,
	output result_t m_result
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EVAL = 5'b00010,
		ST_DIV = 5'b00100,
		ST_EMIT_A = 5'b01000,
		ST_EMIT_B = 5'b10000
	} st_t;

	st_t state_q;
	st_t state_d;
	cmd_t cmd_q;
	logic [4:0] sens_q;
	logic [10:0] jump_q;

	logic click_held_q;
	logic [6:0] last_cc_q;
	logic [11:0] pprev_x_q;
	logic [11:0] pprev_y_q;
	logic pvalid_q;
	logic pactive_q;
	logic [11:0] sprev_y_q;
	logic svalid_q;
	logic sactive_q;

	logic click_pend_q;
	logic sec_valid_q;
	result_t res_b_q;
	logic sx_q;
	logic sy_q;
	logic m_valid_q;
	result_t m_result_q;

	logic [7:0] b0, b1, b2, b3, b4, b5, b6;
	logic click;
	logic [6:0] count;
	logic tip;
	logic [11:0] x, y;
	logic cnt_chg, pv_eff, sv_eff;
	logic [12:0] dx, dy, dsy, nx, ny, nsy;
	logic [11:0] ax, ay, asy;
	logic [11:0] lim;
	logic [12:0] q8, s_full;
	logic [7:0] s_sat;
	logic scroll_hit, move_try;
	logic pv_n, sv_n, pa_n, sa_n;
	result_t res_eval;
	result_t res_move;
	result_t res_click;
	logic slot_free;
	logic div_start;
	logic bx_busy, by_busy;
	logic [11:0] qx, qy;
	logic [11:0] mx, my;

	assign b0 = cmd_q.hdr[0];
	assign b1 = cmd_q.hdr[1];
	assign b2 = cmd_q.hdr[2];
	assign b3 = cmd_q.hdr[3];
	assign b4 = cmd_q.hdr[4];
	assign b5 = cmd_q.hdr[5];
	assign b6 = cmd_q.hdr[6];

	assign click = cmd_q.tail_byte[7];
	assign count = cmd_q.tail_byte[6:0];
	assign tip = b0[1];
	assign x = {b2[3:0], b1};
	assign y = {b3, b2[7:4]};
	assign cnt_chg = count != last_cc_q;
	assign pv_eff = pvalid_q && !cnt_chg;
	assign sv_eff = svalid_q && !cnt_chg;
	assign lim = {1'b0, jump_q};

	assign dx = {1'b0, x} - {1'b0, pprev_x_q};
	assign dy = {1'b0, y} - {1'b0, pprev_y_q};
	assign dsy = {1'b0, y} - {1'b0, sprev_y_q};
	assign nx = dx[12] ? -dx : dx;
	assign ny = dy[12] ? -dy : dy;
	assign nsy = dsy[12] ? -dsy : dsy;
	assign ax = nx[11:0];
	assign ay = ny[11:0];
	assign asy = nsy[11:0];

	// scroll step, truncating toward zero then negated and clamped
	always_comb begin
		q8 = 13'($signed(dsy) >>> 3);
		if (dsy[12] && dsy[2:0] != 3'd0) begin
			q8 = q8 + 13'd1;
		end
		s_full = -q8;
		if ($signed(s_full) > 13'sd127) begin
			s_sat = 8'h7F;
		end else if ($signed(s_full) < -13'sd128) begin
			s_sat = 8'h80;
		end else begin
			s_sat = s_full[7:0];
		end
	end

	assign scroll_hit = count == CONTACT_TWO && tip && sv_eff && asy < lim && q8 != 13'd0;
	assign move_try = count == CONTACT_ONE && tip && pv_eff && ax < lim && ay < lim;

	always_comb begin
		pv_n = pv_eff;
		sv_n = sv_eff;
		pa_n = pactive_q;
		sa_n = sactive_q;
		if (count == CONTACT_TWO) begin
			sv_n = tip;
			sa_n = tip;
		end else if (count == CONTACT_ONE && tip) begin
			pv_n = 1'b1;
			pa_n = 1'b1;
		end else if (count == CONTACT_NONE && (pactive_q || sactive_q)) begin
			pv_n = 1'b0;
			sv_n = 1'b0;
			pa_n = 1'b0;
			sa_n = 1'b0;
		end
	end

	always_comb begin
		res_eval = '0;
		res_eval.last_of_run = 1'b1;
		unique case (cmd_q.kind)
			KIND_WIDE: begin
				res_eval.buttons = b0[4:0];
				res_eval.move_x = {b3[3:0], b2};
				res_eval.move_y = {b4, b3[7:4]};
				res_eval.scroll_vertical = b5;
				res_eval.scroll_horizontal = b6;
			end
			KIND_PAD: begin
				res_eval.scroll_vertical = s_sat;
			end
			default: begin
				res_eval.buttons = {2'b00, b0[2:0]};
				res_eval.move_x = {{4{b1[7]}}, b1};
				res_eval.move_y = {{4{b2[7]}}, b2};
				res_eval.scroll_vertical = b3;
			end
		endcase
	end

	always_comb begin
		res_move = '0;
		res_move.buttons = {4'b0000, click_held_q};
		res_move.move_x = mx;
		res_move.move_y = my;
		res_move.last_of_run = 1'b1;
		res_click = '0;
		res_click.buttons = {4'b0000, click_held_q};
		res_click.last_of_run = !sec_valid_q;
	end

	assign mx = sx_q ? -qx : qx;
	assign my = sy_q ? -qy : qy;
	assign slot_free = !m_valid_q || m_ready;
	assign pop = state_q == ST_IDLE && !q_status.empty;
	assign div_start = state_q == ST_EVAL && cmd_q.kind == KIND_PAD && move_try;

	hprc_divider u_div_x (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(ax),
		.divisor(sens_q),
		.busy(bx_busy),
		.quotient(qx)
	);

	hprc_divider u_div_y (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(ay),
		.divisor(sens_q),
		.busy(by_busy),
		.quotient(qy)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (cmd_q.kind != KIND_PAD) begin
					state_d = ST_EMIT_B;
				end else if (move_try) begin
					state_d = ST_DIV;
				end else if (click != click_held_q) begin
					state_d = ST_EMIT_A;
				end else if (scroll_hit) begin
					state_d = ST_EMIT_B;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (!bx_busy) begin
					if (click_pend_q) begin
						state_d = ST_EMIT_A;
					end else if (qx != 12'd0 || qy != 12'd0) begin
						state_d = ST_EMIT_B;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT_A: begin
				if (slot_free) begin
					state_d = sec_valid_q ? ST_EMIT_B : ST_IDLE;
				end
			end
			ST_EMIT_B: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sens_q <= SENS_RESET;
			jump_q <= JUMP_RESET;
			click_held_q <= 1'b0;
			last_cc_q <= '0;
			pprev_x_q <= '0;
			pprev_y_q <= '0;
			pvalid_q <= 1'b0;
			pactive_q <= 1'b0;
			sprev_y_q <= '0;
			svalid_q <= 1'b0;
			sactive_q <= 1'b0;
			click_pend_q <= 1'b0;
			sec_valid_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SENS: sens_q <= cfg_data[4:0];
					REG_JUMP: jump_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_EVAL) begin
				click_pend_q <= cmd_q.kind == KIND_PAD && click != click_held_q;
				sec_valid_q <= cmd_q.kind != KIND_PAD || scroll_hit;
				if (cmd_q.kind == KIND_PAD) begin
					click_held_q <= click;
					last_cc_q <= count;
					pvalid_q <= pv_n;
					svalid_q <= sv_n;
					pactive_q <= pa_n;
					sactive_q <= sa_n;
					if (count == CONTACT_TWO) begin
						sprev_y_q <= y;
					end else if (count == CONTACT_ONE && tip) begin
						pprev_x_q <= x;
						pprev_y_q <= y;
					end
				end
			end
			if (state_q == ST_DIV && !bx_busy) begin
				sec_valid_q <= qx != 12'd0 || qy != 12'd0;
			end
			if ((state_q == ST_EMIT_A || state_q == ST_EMIT_B) && slot_free) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (state_q == ST_EVAL) begin
			res_b_q <= res_eval;
			sx_q <= dx[12];
			sy_q <= dy[12];
		end
		if (state_q == ST_DIV && !bx_busy) begin
			res_b_q <= res_move;
		end
		if (state_q == ST_EMIT_A && slot_free) begin
			m_result_q <= res_click;
		end else if (state_q == ST_EMIT_B && slot_free) begin
			m_result_q <= res_b_q;
		end
	end

	assign m_valid = m_valid_q;
	assign m_result = m_result_q;

	`HPRC_ASSERT(a_div_pad, clk, arst_n, state_q == ST_DIV |-> cmd_q.kind == KIND_PAD, "divide on a non trackpad report")
	`HPRC_ASSERT(a_div_lockstep, clk, arst_n, bx_busy == by_busy, "x and y dividers out of step")
	`HPRC_ASSERT(a_emit_b_has_word, clk, arst_n, state_q == ST_EMIT_B |-> sec_valid_q, "second word state without a word")
endmodule
`default_nettype wire

### rtl/core/hid_pointer_report_converter_unit.sv
// path: a report's end byte is queued, then popped into the command register and decoded
// in ST_EVAL; a one-finger trackpad move runs the 12-step delta divider in ST_DIV before
// the result word is registered in ST_EMIT_A or ST_EMIT_B. throughput: one byte per cycle
// into a 2-entry report queue while it is not full; the back end pops one report at a time
// reset: arst_n clears byte count, queue, trackpad state and output valid; registers reload
// their defaults (divisor 1, jump limit 150)
`timescale 1ns / 1ps
`default_nettype none
module hid_pointer_report_converter_unit
	import hprc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata, // report_byte
	input wire logic s_axis_tlast,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// buttons, move_x, move_y, scroll_vertical, scroll_horizontal, zero fill
	output logic [47:0] m_axis_tdata,
	output logic m_axis_tlast,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [10:0] cfg_data
);
	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head_cmd;
	q_status_t q_status;
	result_t result;

	hprc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.q_status(q_status),
		.push(push),
		.push_cmd(push_cmd)
	);

	hprc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.head_cmd(head_cmd),
		.status(q_status)
	);

	hprc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_cmd(head_cmd),
		.q_status(q_status),
		.pop(pop),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_result(result)
	);

	assign m_axis_tdata = {3'b000, result.scroll_horizontal, result.scroll_vertical,
		result.move_y, result.move_x, result.buttons};
	assign m_axis_tlast = result.last_of_run;
endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import hprc_pkg::*;

	localparam int SCROLL_DIV = 8;
	localparam int COORD_MAX = 4095;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_BYTES = 250;

	class pointer_scoreboard;
		result_t expected_q[$];
		int errors;
		int words_checked;
		logic [4:0] sens;
		logic [10:0] jump;
		logic [4:0] byte_cnt;
		logic [7:0] hdr[HDR_DEPTH];
		bit click_held;
		logic [6:0] contacts;
		int ptr_x;
		int ptr_y;
		bit ptr_valid;
		bit ptr_active;
		int scr_y;
		bit scr_valid;
		bit scr_active;

		function new();
			errors = 0;
			words_checked = 0;
			sens = SENS_RESET;
			jump = JUMP_RESET;
			byte_cnt = '0;
			click_held = 0;
			contacts = CONTACT_NONE;
			ptr_x = 0;
			ptr_y = 0;
			ptr_valid = 0;
			ptr_active = 0;
			scr_y = 0;
			scr_valid = 0;
			scr_active = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [10:0] val);
			if (idx == REG_SENS) begin
				sens = val[4:0];
			end else begin
				jump = val;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int mag(int v);
			return (v < 0) ? -v : v;
		endfunction

		function void push(logic [4:0] btn, logic [11:0] mx, logic [11:0] my,
			logic [7:0] sv, logic [7:0] sh);
			result_t r;
			r.buttons = btn;
			r.move_x = mx;
			r.move_y = my;
			r.scroll_vertical = sv;
			r.scroll_horizontal = sh;
			r.last_of_run = 1'b0;
			expected_q.push_back(r);
		endfunction

		function int decode_pad(logic [7:0] fin);
			bit click;
			logic [6:0] count;
			bit tip;
			int x;
			int y;
			int dx;
			int dy;
			int s;
			int d;
			int n;
			click = fin[7];
			count = fin[6:0];
			tip = hdr[0][1];
			x = int'({hdr[2][3:0], hdr[1]});
			y = int'({hdr[3], hdr[2][7:4]});
			n = 0;
			if (click != click_held) begin
				click_held = click;
				push({4'b0, click}, '0, '0, '0, '0);
				n++;
			end
			if (count != contacts) begin
				ptr_valid = 0;
				scr_valid = 0;
				contacts = count;
			end
			if (count == CONTACT_TWO) begin
				if (tip && scr_valid) begin
					dy = y - scr_y;
					if (mag(dy) < int'(jump)) begin
						s = -(dy / SCROLL_DIV);
						if (s > 127) s = 127;
						if (s < -128) s = -128;
						if (s != 0) begin
							push('0, '0, '0, s[7:0], '0);
							n++;
						end
					end
				end
				scr_y = y;
				scr_valid = tip;
				scr_active = tip;
			end else if (count == CONTACT_ONE && tip) begin
				if (ptr_valid) begin
					dx = x - ptr_x;
					dy = y - ptr_y;
					if (mag(dx) < int'(jump) && mag(dy) < int'(jump)) begin
						d = (sens == 0) ? 1 : int'(sens);
						dx = dx / d;
						dy = dy / d;
						if (dx != 0 || dy != 0) begin
							push({4'b0, click_held}, dx[11:0], dy[11:0], '0, '0);
							n++;
						end
					end
				end
				ptr_x = x;
				ptr_y = y;
				ptr_valid = 1;
				ptr_active = 1;
			end else if (count == CONTACT_NONE) begin
				if (ptr_active || scr_active) begin
					ptr_active = 0;
					ptr_valid = 0;
					scr_active = 0;
					scr_valid = 0;
				end
			end
			return n;
		endfunction

		function void note_byte(logic [7:0] b, logic is_end);
			int len;
			int n;
			if (byte_cnt < HDR_DEPTH) hdr[byte_cnt] = b;
			if (byte_cnt < CNT_MAX) byte_cnt++;
			if (!is_end) return;
			len = int'(byte_cnt);
			byte_cnt = '0;
			n = 0;
			if (len == WIDE_LEN) begin
				push(hdr[0][4:0], {hdr[3][3:0], hdr[2]}, {hdr[4], hdr[3][7:4]},
					hdr[5], hdr[6]);
				n = 1;
			end else if (len == PAD_LEN) begin
				n = decode_pad(b);
			end else if (len >= BASIC_MIN_LEN && len < WIDE_LEN) begin
				push({2'b0, hdr[0][2:0]}, {{4{hdr[1][7]}}, hdr[1]},
					{{4{hdr[2][7]}}, hdr[2]}, hdr[3], 8'h00);
				n = 1;
			end
			if (n > 0) expected_q[expected_q.size() - 1].last_of_run = 1'b1;
		endfunction

		function void compare_field(string name, logic [11:0] exp_v, logic [11:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s expected %0d actual %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_word(logic [47:0] d, logic tl);
			result_t e;
			words_checked++;
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: %h last %b", d, tl);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare_field("buttons", 12'(e.buttons), 12'(d[4:0]));
			compare_field("move_x", e.move_x, d[16:5]);
			compare_field("move_y", e.move_y, d[28:17]);
			compare_field("scroll_vertical", 12'(e.scroll_vertical), 12'(d[36:29]));
			compare_field("scroll_horizontal", 12'(e.scroll_horizontal), 12'(d[44:37]));
			compare_field("last_of_run", 12'(e.last_of_run), 12'(tl));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [10:0] cfg_data = '0;

	pointer_scoreboard sb = new();
	int tx_pct = 11;
	int rx_pct = 49;
	int bytes_in = 0;
	int reports_sent = 0;
	int pad_reports = 0;
	int stall_cycles = 0;
	logic [7:0] rpt[$];
	int fx = 2048;
	int fy = 2048;
	bit fclick = 0;
	logic [6:0] fcount = CONTACT_ONE;
	int sens_tab[6] = '{1, 4, 16, 0, 31, 1};
	int jump_tab[6] = '{150, 600, 2047, 0, 1, 300};

	hid_pointer_report_converter_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rx_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_byte(s_axis_tdata, s_axis_tlast);
				bytes_in++;
			end
			if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic is_end);
		while ($urandom_range(0, 99) < tx_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= is_end;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_rpt();
		foreach (rpt[i]) send_byte(rpt[i], i == rpt.size() - 1);
		reports_sent++;
	endtask

	task automatic fill_random(int len);
		rpt = {};
		repeat (len) rpt.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic pad_rpt(bit tip, int x, int y, bit click, logic [6:0] count);
		fill_random(PAD_LEN);
		rpt[0][1] = tip;
		rpt[1] = x[7:0];
		rpt[2] = {y[3:0], x[11:8]};
		rpt[3] = y[11:4];
		rpt[PAD_LEN - 1] = {click, count};
		send_rpt();
		pad_reports++;
	endtask

	task automatic hold_until_empty();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic drain();
		hold_until_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [10:0] sens_val, logic [10:0] jump_val);
		cfg_we <= 1'b1;
		cfg_index <= REG_SENS;
		cfg_data <= sens_val;
		sb.write_reg(REG_SENS, sens_val);
		@(posedge clk);
		cfg_index <= REG_JUMP;
		cfg_data <= jump_val;
		sb.write_reg(REG_JUMP, jump_val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_pad();
		int step;
		int pick;
		bit tip;
		if ($urandom_range(0, 99) < 8) fclick = ~fclick;
		if ($urandom_range(0, 99) < 12) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) fcount = CONTACT_NONE;
			else if (pick < 62) fcount = CONTACT_ONE;
			else if (pick < 95) fcount = CONTACT_TWO;
			else fcount = 7'($urandom_range(3, 127));
		end
		tip = ($urandom_range(0, 99) < 90);
		step = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 40) : $urandom_range(0, 2100);
		fx = fx + int'($urandom_range(0, 2 * step)) - step;
		fy = fy + int'($urandom_range(0, 2 * step)) - step;
		fx = (fx < 0) ? 0 : ((fx > COORD_MAX) ? COORD_MAX : fx);
		fy = (fy < 0) ? 0 : ((fy > COORD_MAX) ? COORD_MAX : fy);
		pad_rpt(tip, fx, fy, fclick, fcount);
	endtask

	task automatic random_report();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			random_pad();
		end else begin
			if (pick < 72) fill_random($urandom_range(4, 6));
			else if (pick < 82) fill_random(WIDE_LEN);
			else fill_random($urandom_range(1, 40));
			send_rpt();
		end
	endtask

	task automatic directed();
		rpt = {8'h00, 8'h7F, 8'h80, 8'hFF};
		send_rpt();
		rpt = {8'hFF, 8'h80, 8'h7F, 8'h00, 8'hAA};
		send_rpt();
		fill_random(6);
		send_rpt();
		rpt = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_rpt();
		rpt = {8'hE0, 8'h00, 8'h00, 8'h0F, 8'hF0, 8'h80, 8'h7F};
		send_rpt();
		fill_random(1);
		send_rpt();
		fill_random(3);
		send_rpt();
		fill_random(8);
		send_rpt();
		fill_random(35);
		send_rpt();
		// one finger: touch, move, click on, jump, click off, no tip
		pad_rpt(1, 100, 100, 0, CONTACT_ONE);
		pad_rpt(1, 110, 95, 0, CONTACT_ONE);
		pad_rpt(1, 110, 95, 1, CONTACT_ONE);
		pad_rpt(1, 4000, 4000, 1, CONTACT_ONE);
		pad_rpt(1, 4000, 4000, 0, CONTACT_ONE);
		pad_rpt(0, 4000, 4000, 0, CONTACT_ONE);
		// two fingers: start, scroll, still, jump
		pad_rpt(1, 4000, 3900, 0, CONTACT_TWO);
		pad_rpt(1, 4000, 3800, 0, CONTACT_TWO);
		pad_rpt(1, 4000, 3800, 0, CONTACT_TWO);
		pad_rpt(1, 4000, 3000, 0, CONTACT_TWO);
		pad_rpt(0, 0, 0, 0, CONTACT_NONE);
		pad_rpt(1, 5, 5, 0, 7'd3);
		pad_rpt(1, 5, 5, 1, 7'd127);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				drain();
				set_config(11'(sens_tab[ph]), 11'(jump_tab[ph]));
			end
			tx_pct = (ph < 2) ? 11 : ((ph < 4) ? 49 : 0);
			rx_pct = (ph < 2) ? 49 : ((ph < 4) ? 11 : 0);
			// large two-finger swings, saturate when the jump limit allows
			pad_rpt(1, 2048, 0, fclick, CONTACT_TWO);
			pad_rpt(1, 2048, 2000, fclick, CONTACT_TWO);
			pad_rpt(1, 2048, 0, fclick, CONTACT_TWO);
			fcount = CONTACT_TWO;
			while (bytes_in < (ph + 1) * PHASE_BYTES) begin
				random_report();
				if ($urandom_range(0, 29) == 0) hold_until_empty();
			end
		end
		drain();
		$display("covered %0d reports (%0d trackpad), %0d bytes, %0d result words",
			reports_sent, pad_reports, bytes_in, sb.words_checked);
		$display("six register settings incl. zero and maximum values, three idle patterns");
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
